@@ design/hvrs_pkg.sv @@
package hvrs_pkg;

   typedef enum logic [1:0] {
      ACT_VOLT   = 2'd0,
      ACT_ENABLE = 2'd1,
      ACT_SWITCH = 2'd2
   } action_type;

   localparam logic [2:0] KIND_TICK     = 3'd0;
   localparam logic [2:0] KIND_SET      = 3'd1;
   localparam logic [2:0] KIND_ENABLE   = 3'd2;
   localparam logic [2:0] KIND_POLARITY = 3'd3;
   localparam logic [2:0] KIND_OUTPUT   = 3'd4;

   localparam logic [2:0] REG_MIN_VOLTAGE    = 3'd0;
   localparam logic [2:0] REG_MAX_VOLTAGE    = 3'd1;
   localparam logic [2:0] REG_RAMP_STEP      = 3'd2;
   localparam logic [2:0] REG_RAMP_INTERVAL  = 3'd3;
   localparam logic [2:0] REG_ENABLE_DELAY   = 3'd4;
   localparam logic [2:0] REG_POLARITY_DELAY = 3'd5;
   localparam logic [2:0] REG_FOLLOW_ENABLE  = 3'd6;

   // Pre-regulator map in unsigned Q16: 0.15789 and 21.05263.
   localparam logic [13:0] PRE_GAIN   = 14'd10347;
   localparam logic [29:0] PRE_OFFSET = 30'd1379705;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_RAMP, OP_EN, OP_APPLY, OP_POL,
      OP_ENCMD, OP_ENPIN, OP_OUT, OP_POLCMD, OP_FLUSH
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RAMP, ST_EN, ST_APPLY, ST_POL,
      ST_ENCMD, ST_ENPIN, ST_OUT, ST_POLCMD, ST_FLUSH
   } state_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic       stall;
      logic       en_fire;
      logic       from_tick;
      logic       last_ch;
      logic       enc_same;
      logic       flag;
      logic       follow;
      logic       in_ok;
      logic [2:0] in_kind;
   } status_type;

   typedef struct packed {
      action_type  action;
      logic [1:0]  ch;
      logic [15:0] volt;
      logic        en;
      logic        pos;
      logic        neg;
   } result_type;

   function automatic logic [13:0] pre_of(input logic [15:0] v);
      logic [29:0] acc;
      acc = 30'(v) * 30'(PRE_GAIN) + PRE_OFFSET;
      return acc[29:16];
   endfunction

endpackage

@@ design/hvrs_datapath.sv @@
module hvrs_datapath
   import hvrs_pkg::*;
#(
   parameter int CHANNELS = 3,
   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [2:0]  req_tuser,
   input  logic [23:0] req_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        rsp_tready,
   output logic        rsp_tvalid,
   output logic [39:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast
);

   logic [15:0] min_ff, max_ff, step_ff, interval_ff, edelay_ff, pdelay_ff;
   logic        follow_ff;

   logic            from_tick_ff, from_tick_in;
   logic            flag_ff, flag_in;
   logic [15:0]     volt_ff, volt_in;
   logic [CH_W-1:0] ch_ff, ch_in;
   logic [31:0]     tick_ff, tick_in;

   logic [15:0] set_ff    [CHANNELS], set_in    [CHANNELS];
   logic [15:0] reqv_ff   [CHANNELS], reqv_in   [CHANNELS];
   logic        ramp_ff   [CHANNELS], ramp_in   [CHANNELS];
   logic [31:0] rstamp_ff [CHANNELS], rstamp_in [CHANNELS];
   logic        en_ff     [CHANNELS], en_in     [CHANNELS];
   logic        enp_ff    [CHANNELS], enp_in    [CHANNELS];
   logic [31:0] estamp_ff [CHANNELS], estamp_in [CHANNELS];
   logic        pol_ff    [CHANNELS], pol_in    [CHANNELS];
   logic        polp_ff   [CHANNELS], polp_in   [CHANNELS];
   logic [31:0] pstamp_ff [CHANNELS], pstamp_in [CHANNELS];
   logic        outon_ff  [CHANNELS], outon_in  [CHANNELS];

   result_type  pend_ff, pend_in;
   logic        pend_v_ff, pend_v_in;
   result_type  rsp_ff, rsp_in;
   logic [13:0] rsp_pre_ff, rsp_pre_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [1:0]  req_ch;
   logic [15:0] set_c, tgt, apply_v, span, stepped;
   logic        far, in_range, due_r, due_e, due_p, last_ch;
   logic        emit, stall, move, out_free, out_ok, pol_ok;
   result_type  res;

   assign req_ch  = req_tdata[1:0];
   assign set_c   = set_ff[ch_ff];
   assign apply_v = from_tick_ff ? reqv_ff[ch_ff] : volt_ff;
   assign tgt     = (cmd.op == OP_RAMP) ? reqv_ff[ch_ff] : apply_v;
   assign span    = (tgt > set_c) ? tgt - set_c : set_c - tgt;
   assign far     = span > step_ff;
   assign stepped = (set_c < tgt) ? set_c + step_ff : set_c - step_ff;
   assign in_range = (apply_v >= min_ff) && (apply_v <= max_ff);
   assign due_r   = (tick_ff - rstamp_ff[ch_ff]) >= {16'b0, interval_ff};
   assign due_e   = (tick_ff - estamp_ff[ch_ff]) >= {16'b0, edelay_ff};
   assign due_p   = (tick_ff - pstamp_ff[ch_ff]) >= {16'b0, pdelay_ff};
   assign last_ch = ch_ff == CH_W'(CHANNELS - 1);
   assign out_ok  = !(follow_ff && en_ff[ch_ff] && !enp_ff[ch_ff] && flag_ff);
   assign pol_ok  = (flag_ff != pol_ff[ch_ff]) && !(follow_ff && en_ff[ch_ff])
                    && !polp_ff[ch_ff];
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Result produced by the current step, if any.
   always_comb begin
      emit       = 1'b0;
      res        = '0;
      res.ch     = 2'(ch_ff);
      res.action = ACT_VOLT;
      unique case (cmd.op)
         OP_RAMP: begin
            emit     = ramp_ff[ch_ff] && due_r;
            res.volt = far ? stepped : reqv_ff[ch_ff];
         end
         OP_EN: begin
            emit       = enp_ff[ch_ff] && due_e;
            res.action = ACT_ENABLE;
            res.en     = 1'b1;
         end
         OP_APPLY: begin
            emit     = in_range;
            res.volt = far ? stepped : apply_v;
         end
         OP_POL: begin
            emit       = polp_ff[ch_ff] && due_p;
            res.action = ACT_SWITCH;
            res.pos    = outon_ff[ch_ff] && !pol_ff[ch_ff];
            res.neg    = outon_ff[ch_ff] && pol_ff[ch_ff];
         end
         OP_ENCMD: begin
            emit = flag_ff != en_ff[ch_ff];
            if (flag_ff) begin
               res.volt = min_ff;
            end else begin
               res.action = ACT_ENABLE;
            end
         end
         OP_ENPIN: begin
            emit       = 1'b1;
            res.action = ACT_ENABLE;
            res.en     = 1'b1;
         end
         OP_OUT: begin
            emit       = out_ok;
            res.action = ACT_SWITCH;
            res.pos    = flag_ff && !pol_ff[ch_ff];
            res.neg    = flag_ff && pol_ff[ch_ff];
         end
         OP_POLCMD: begin
            emit       = pol_ok;
            res.action = ACT_SWITCH;
         end
         default: emit = 1'b0;
      endcase
   end

   assign stall = pend_v_ff && !out_free && (emit || cmd.op == OP_FLUSH);
   assign move  = pend_v_ff && (emit || cmd.op == OP_FLUSH) && !stall;

   always_comb begin
      from_tick_in = from_tick_ff;
      flag_in      = flag_ff;
      volt_in      = volt_ff;
      ch_in        = ch_ff;
      tick_in      = tick_ff;
      set_in       = set_ff;
      reqv_in      = reqv_ff;
      ramp_in      = ramp_ff;
      rstamp_in    = rstamp_ff;
      en_in        = en_ff;
      enp_in       = enp_ff;
      estamp_in    = estamp_ff;
      pol_in       = pol_ff;
      polp_in      = polp_ff;
      pstamp_in    = pstamp_ff;
      outon_in     = outon_ff;
      pend_in      = pend_ff;
      pend_v_in    = pend_v_ff;
      rsp_in       = rsp_ff;
      rsp_pre_in   = rsp_pre_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (cmd.op == OP_LOAD) begin
         from_tick_in = req_tuser == KIND_TICK;
         flag_in      = req_tdata[18];
         volt_in      = req_tdata[17:2];
         ch_in        = (req_tuser == KIND_TICK) ? '0 : CH_W'(req_ch);
         if (req_tuser == KIND_TICK) begin
            tick_in = tick_ff + 32'd1;
         end
      end

      if (!stall) begin
         unique case (cmd.op)
            OP_RAMP: begin
               if (ramp_ff[ch_ff] && due_r) begin
                  if (far) begin
                     set_in[ch_ff]    = stepped;
                     rstamp_in[ch_ff] = tick_ff;
                  end else begin
                     set_in[ch_ff]  = reqv_ff[ch_ff];
                     ramp_in[ch_ff] = 1'b0;
                  end
               end
            end
            OP_EN: begin
               if (enp_ff[ch_ff] && due_e) begin
                  enp_in[ch_ff] = 1'b0;
               end
            end
            OP_APPLY: begin
               if (in_range) begin
                  reqv_in[ch_ff] = apply_v;
                  if (far) begin
                     set_in[ch_ff]    = stepped;
                     ramp_in[ch_ff]   = 1'b1;
                     rstamp_in[ch_ff] = tick_ff;
                  end else begin
                     set_in[ch_ff] = apply_v;
                  end
               end
            end
            OP_POL: begin
               if (polp_ff[ch_ff] && due_p) begin
                  polp_in[ch_ff] = 1'b0;
               end
               if (from_tick_ff && !last_ch) begin
                  ch_in = ch_ff + CH_W'(1);
               end
            end
            OP_ENCMD: begin
               if (flag_ff != en_ff[ch_ff]) begin
                  if (flag_ff) begin
                     set_in[ch_ff] = min_ff;
                  end else begin
                     en_in[ch_ff]  = 1'b0;
                     enp_in[ch_ff] = 1'b0;
                  end
               end
            end
            OP_ENPIN: begin
               en_in[ch_ff]     = 1'b1;
               enp_in[ch_ff]    = 1'b1;
               estamp_in[ch_ff] = tick_ff;
            end
            OP_OUT: begin
               if (out_ok) begin
                  outon_in[ch_ff] = flag_ff;
               end
            end
            OP_POLCMD: begin
               if (pol_ok) begin
                  pol_in[ch_ff]    = flag_ff;
                  polp_in[ch_ff]   = 1'b1;
                  pstamp_in[ch_ff] = tick_ff;
               end
            end
            default: ;
         endcase

         // Hold one result back so the last one of an item can be marked.
         if (move) begin
            rsp_in       = pend_ff;
            rsp_pre_in   = (pend_ff.action == ACT_VOLT) ? pre_of(pend_ff.volt) : 14'd0;
            rsp_last_in  = cmd.op == OP_FLUSH;
            rsp_valid_in = 1'b1;
         end
         if (emit) begin
            pend_in   = res;
            pend_v_in = 1'b1;
         end else if (cmd.op == OP_FLUSH) begin
            pend_v_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff       <= 16'd0;
         max_ff       <= 16'd65535;
         step_ff      <= 16'd10;
         interval_ff  <= 16'd100;
         edelay_ff    <= 16'd100;
         pdelay_ff    <= 16'd100;
         follow_ff    <= 1'b0;
         tick_ff      <= '0;
         ch_ff        <= '0;
         from_tick_ff <= 1'b0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            set_ff[i]    <= '0;
            reqv_ff[i]   <= '0;
            ramp_ff[i]   <= 1'b0;
            rstamp_ff[i] <= '0;
            en_ff[i]     <= 1'b0;
            enp_ff[i]    <= 1'b0;
            estamp_ff[i] <= '0;
            pol_ff[i]    <= 1'b0;
            polp_ff[i]   <= 1'b0;
            pstamp_ff[i] <= '0;
            outon_ff[i]  <= 1'b0;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_MIN_VOLTAGE:    min_ff      <= csr_wdata;
               REG_MAX_VOLTAGE:    max_ff      <= csr_wdata;
               REG_RAMP_STEP:      step_ff     <= csr_wdata;
               REG_RAMP_INTERVAL:  interval_ff <= csr_wdata;
               REG_ENABLE_DELAY:   edelay_ff   <= csr_wdata;
               REG_POLARITY_DELAY: pdelay_ff   <= csr_wdata;
               REG_FOLLOW_ENABLE:  follow_ff   <= csr_wdata[0];
               default: ;
            endcase
         end
         tick_ff      <= tick_in;
         ch_ff        <= ch_in;
         from_tick_ff <= from_tick_in;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
         set_ff       <= set_in;
         reqv_ff      <= reqv_in;
         ramp_ff      <= ramp_in;
         rstamp_ff    <= rstamp_in;
         en_ff        <= en_in;
         enp_ff       <= enp_in;
         estamp_ff    <= estamp_in;
         pol_ff       <= pol_in;
         polp_ff      <= polp_in;
         pstamp_ff    <= pstamp_in;
         outon_ff     <= outon_in;
      end
   end

   always_ff @(posedge clock) begin
      flag_ff     <= flag_in;
      volt_ff     <= volt_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
      rsp_pre_ff  <= rsp_pre_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      status           = '0;
      status.stall     = stall;
      status.en_fire   = enp_ff[ch_ff] && due_e;
      status.from_tick = from_tick_ff;
      status.last_ch   = last_ch;
      status.enc_same  = flag_ff == en_ff[ch_ff];
      status.flag      = flag_ff;
      status.follow    = follow_ff;
      status.in_ok     = int'(req_ch) < CHANNELS;
      status.in_kind   = req_tuser;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.action;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {5'b0, rsp_ff.neg, rsp_ff.pos, rsp_ff.en, rsp_pre_ff,
                        rsp_ff.volt, rsp_ff.ch};

   a_pend_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_LOAD |-> !pend_v_ff)
      else $error("result left over from previous item");

   a_pin_no_volt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.action != ACT_VOLT |-> rsp_pre_ff == 14'd0 && rsp_ff.volt == 16'd0)
      else $error("pin action carries a voltage");

endmodule

@@ design/hvrs_controller.sv @@
module hvrs_controller
   import hvrs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.op     = OP_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op = OP_LOAD;
               priority if (status.in_kind == KIND_TICK) begin
                  state_in = ST_RAMP;
               end else if (!status.in_ok) begin
                  state_in = ST_FLUSH;
               end else if (status.in_kind == KIND_SET) begin
                  state_in = ST_APPLY;
               end else if (status.in_kind == KIND_ENABLE) begin
                  state_in = ST_ENCMD;
               end else if (status.in_kind == KIND_POLARITY) begin
                  state_in = ST_POLCMD;
               end else if (status.in_kind == KIND_OUTPUT) begin
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_RAMP: begin
            cmd.op = OP_RAMP;
            if (!status.stall) state_in = ST_EN;
         end
         ST_EN: begin
            cmd.op = OP_EN;
            if (!status.stall) state_in = status.en_fire ? ST_APPLY : ST_POL;
         end
         ST_APPLY: begin
            cmd.op = OP_APPLY;
            if (!status.stall) state_in = status.from_tick ? ST_POL : ST_FLUSH;
         end
         ST_POL: begin
            cmd.op = OP_POL;
            if (!status.stall) begin
               state_in = (status.from_tick && !status.last_ch) ? ST_RAMP : ST_FLUSH;
            end
         end
         ST_ENCMD: begin
            cmd.op = OP_ENCMD;
            if (!status.stall) begin
               priority if (status.enc_same) state_in = ST_FLUSH;
               else if (status.flag)         state_in = ST_ENPIN;
               else if (status.follow)       state_in = ST_OUT;
               else                          state_in = ST_FLUSH;
            end
         end
         ST_ENPIN: begin
            cmd.op = OP_ENPIN;
            if (!status.stall) state_in = status.follow ? ST_OUT : ST_FLUSH;
         end
         ST_OUT: begin
            cmd.op = OP_OUT;
            if (!status.stall) state_in = ST_FLUSH;
         end
         ST_POLCMD: begin
            cmd.op = OP_POLCMD;
            if (!status.stall) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            cmd.op = OP_FLUSH;
            if (!status.stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_enpin_entry: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ENPIN |-> $past(state_ff) == ST_ENCMD || $past(state_ff) == ST_ENPIN)
      else $error("enable pin step entered out of order");

endmodule

@@ design/hv_channel_ramp_sequencer.sv @@
// Steps: a command runs its sequencer steps from transfer to its last result in
//   the output register; a tick runs the ramp, enable, optional apply and
//   polarity steps of the sequencer for each channel in turn.
// Throughput: one item at a time; the next transfer is taken in the cycle after
//   the flush step of the previous item is done. Output stalls stretch this.
// Reset: synchronous, active high; loads CSR defaults, clears control state.
module hv_channel_ramp_sequencer
   import hvrs_pkg::*;
#(
   parameter int CHANNELS = 3
) (
   input  logic        clock,
   input  logic        reset,
   // Command and tick input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // channel[1:0], voltage[17:2], flag[18]
   input  logic [2:0]  req_tuser,   // kind
   // Result output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // out_channel[1:0], out_voltage[17:2],
                                    // pre_voltage[31:18], enable_level[32],
                                    // drive_positive[33], drive_negative[34]
   output logic [1:0]  rsp_tuser,   // action
   output logic        rsp_tlast,   // last
   // Register writes
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // Sequencer: steps through the per-channel actions of one item.
   hvrs_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Channel state, timers, result staging and the output register.
   hvrs_datapath #(.CHANNELS(CHANNELS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
